// File: rtl/core/exlex_pkg.sv
// ----------------------------------------------------------------------------
// exlex_pkg
// Shared types and constants of the expression lexer: token codes, the
// result word, and the command and status groups between sequencer and
// datapath.
// ----------------------------------------------------------------------------
package exlex_pkg;

   localparam int IDENT_MAX    = 16;
   localparam int NUMBER_WIDTH = 32;
   localparam int IDX_W        = $clog2(IDENT_MAX);
   localparam int LEN_W        = $clog2(IDENT_MAX + 1);

   typedef logic [4:0] token_kind_type;

   localparam token_kind_type TK_END    = 5'd0;
   localparam token_kind_type TK_INT    = 5'd1;
   localparam token_kind_type TK_IDENT  = 5'd2;
   localparam token_kind_type TK_TRUE   = 5'd3;
   localparam token_kind_type TK_FALSE  = 5'd4;
   localparam token_kind_type TK_IF     = 5'd5;
   localparam token_kind_type TK_ELSE   = 5'd6;
   localparam token_kind_type TK_EQ     = 5'd7;
   localparam token_kind_type TK_NE     = 5'd8;
   localparam token_kind_type TK_LE     = 5'd9;
   localparam token_kind_type TK_GE     = 5'd10;
   localparam token_kind_type TK_AND    = 5'd11;
   localparam token_kind_type TK_OR     = 5'd12;
   localparam token_kind_type TK_PLUS   = 5'd13;
   localparam token_kind_type TK_MINUS  = 5'd14;
   localparam token_kind_type TK_STAR   = 5'd15;
   localparam token_kind_type TK_SLASH  = 5'd16;
   localparam token_kind_type TK_PCT    = 5'd17;
   localparam token_kind_type TK_LPAREN = 5'd18;
   localparam token_kind_type TK_RPAREN = 5'd19;
   localparam token_kind_type TK_CARET  = 5'd20;
   localparam token_kind_type TK_BANG   = 5'd21;
   localparam token_kind_type TK_ASSIGN = 5'd22;
   localparam token_kind_type TK_LT     = 5'd23;
   localparam token_kind_type TK_GT     = 5'd24;
   localparam token_kind_type TK_LBRACE = 5'd25;
   localparam token_kind_type TK_RBRACE = 5'd26;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_IDENT = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      ES_TOKEN = 2'd0,
      ES_INT   = 2'd1,
      ES_CHAR  = 2'd2
   } emit_sel_type;

   typedef struct packed {
      token_kind_type          token_kind;
      logic [NUMBER_WIDTH-1:0] number_value;
      logic [7:0]              text_char;
      logic [3:0]              text_index;
      logic                    text_end;
      logic                    truncated;
      logic                    run_last;
   } rsp_type;

   typedef struct packed {
      logic           latch;
      logic           pass2;
      logic           emit;
      emit_sel_type   sel;
      token_kind_type kind;
      logic           pend_clr;
      logic           pend_set;
      logic           mode_we;
      scan_mode_type  mode_val;
      logic           acc_clr;
      logic           acc_start;
      logic           acc_step;
      logic           id_clr;
      logic           id_start;
      logic           id_append;
      logic           idx_clr;
      logic           idx_inc;
      logic           fin_set;
      logic           fin_clr;
      logic           drain;
   } cmd_type;

   typedef struct packed {
      logic           finished;
      logic           in_zero;
      logic           in_last;
      logic           cur_last;
      logic           pend_busy;
      logic           pend_pair;
      token_kind_type pair_kind;
      logic           pend_single;
      token_kind_type pend_kind;
      scan_mode_type  mode;
      logic           cur_digit;
      logic           cur_alpha;
      logic           cur_alnum;
      logic           cur_space;
      logic           cur_pend_op;
      logic           cur_single;
      token_kind_type cur_kind;
      logic           kw_hit;
      token_kind_type kw_kind;
      logic           chars_done;
      logic           slot_ok;
      logic           hold_valid;
      logic           out_free;
   } status_type;

endpackage

// File: rtl/core/exlex_if.sv
// ----------------------------------------------------------------------------
// exlex_if
// Valid/ready channels of the expression lexer: source bytes in, token
// results out.
// ----------------------------------------------------------------------------
interface exlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_source;

   modport source (output valid, byte_in, end_of_source, input ready);
   modport sink (input valid, byte_in, end_of_source, output ready);
endinterface

interface exlex_rsp_if
   import exlex_pkg::*;
();
   logic                    valid;
   logic                    ready;
   token_kind_type          token_kind;
   logic [NUMBER_WIDTH-1:0] number_value;
   logic [7:0]              text_char;
   logic [3:0]              text_index;
   logic                    text_end;
   logic                    truncated;
   logic                    run_last;

   modport source (output valid, token_kind, number_value, text_char, text_index,
                   text_end, truncated, run_last, input ready);
   modport sink (input valid, token_kind, number_value, text_char, text_index,
                 text_end, truncated, run_last, output ready);
endinterface

// File: rtl/core/exlex_dp.sv
// ----------------------------------------------------------------------------
// exlex_dp
// Lexer datapath: current byte, pending operator, number accumulator,
// identifier buffer, character classes, and the staging and output
// registers of the result channel.
// ----------------------------------------------------------------------------
module exlex_dp
   import exlex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_source,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_word
);

   logic [7:0]              cur_byte_ff, cur_byte_in;
   logic                    cur_last_ff, cur_last_in;
   logic                    fin_ff, fin_in;
   logic [7:0]              pend_ff, pend_in;
   scan_mode_type           mode_ff, mode_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    ovf_ff, ovf_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [7:0]              buf_ff [IDENT_MAX];
   rsp_type                 hold_ff, hold_in;
   logic                    hold_valid_ff, hold_valid_in;
   rsp_type                 out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;

   logic [7:0]              eff_c;
   logic [3:0]              digit;
   logic                    len_room;
   logic                    buf_we;
   logic [IDX_W-1:0]        buf_addr;
   logic                    out_free;
   logic                    push;
   rsp_type                 new_rec;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   // The terminator pass looks at a zero byte, which closes every open token.
   assign eff_c    = cmd.pass2 ? 8'd0 : cur_byte_ff;
   assign digit    = 4'(eff_c - "0");
   assign len_room = len_ff < LEN_W'(IDENT_MAX);
   assign out_free = !out_valid_ff || rsp_ready;
   assign push     = hold_valid_ff && out_free && (cmd.emit || cmd.drain);

   // Character classes, operator lookups and keyword matching.
   always_comb begin
      status             = '0;
      status.finished    = fin_ff;
      status.in_zero     = (req_byte_in == 8'd0);
      status.in_last     = req_end_of_source;
      status.cur_last    = cur_last_ff;
      status.pend_busy   = (pend_ff != 8'd0);
      status.mode        = mode_ff;
      status.cur_digit   = is_digit(eff_c);
      status.cur_alpha   = is_alpha(eff_c);
      status.cur_alnum   = is_digit(eff_c) || is_alpha(eff_c);
      status.cur_space   = (eff_c == " ") || ((eff_c >= 8'd9) && (eff_c <= 8'd13));
      status.cur_pend_op = (eff_c == "=") || (eff_c == "!") || (eff_c == "<") ||
                           (eff_c == ">") || (eff_c == "&") || (eff_c == "|");
      status.chars_done  = ({1'b0, idx_ff} + LEN_W'(1)) == len_ff;
      status.slot_ok     = !hold_valid_ff || out_free;
      status.hold_valid  = hold_valid_ff;
      status.out_free    = out_free;

      if (eff_c == "=") begin
         unique case (pend_ff)
            "=": begin status.pend_pair = 1'b1; status.pair_kind = TK_EQ; end
            "!": begin status.pend_pair = 1'b1; status.pair_kind = TK_NE; end
            "<": begin status.pend_pair = 1'b1; status.pair_kind = TK_LE; end
            ">": begin status.pend_pair = 1'b1; status.pair_kind = TK_GE; end
            default: ;
         endcase
      end else if ((eff_c == "&") && (pend_ff == "&")) begin
         status.pend_pair = 1'b1;
         status.pair_kind = TK_AND;
      end else if ((eff_c == "|") && (pend_ff == "|")) begin
         status.pend_pair = 1'b1;
         status.pair_kind = TK_OR;
      end

      unique case (pend_ff)
         "=": begin status.pend_single = 1'b1; status.pend_kind = TK_ASSIGN; end
         "!": begin status.pend_single = 1'b1; status.pend_kind = TK_BANG; end
         "<": begin status.pend_single = 1'b1; status.pend_kind = TK_LT; end
         ">": begin status.pend_single = 1'b1; status.pend_kind = TK_GT; end
         default: ;
      endcase

      unique case (eff_c)
         "+": begin status.cur_single = 1'b1; status.cur_kind = TK_PLUS; end
         "-": begin status.cur_single = 1'b1; status.cur_kind = TK_MINUS; end
         "*": begin status.cur_single = 1'b1; status.cur_kind = TK_STAR; end
         "/": begin status.cur_single = 1'b1; status.cur_kind = TK_SLASH; end
         "%": begin status.cur_single = 1'b1; status.cur_kind = TK_PCT; end
         "(": begin status.cur_single = 1'b1; status.cur_kind = TK_LPAREN; end
         ")": begin status.cur_single = 1'b1; status.cur_kind = TK_RPAREN; end
         "^": begin status.cur_single = 1'b1; status.cur_kind = TK_CARET; end
         "{": begin status.cur_single = 1'b1; status.cur_kind = TK_LBRACE; end
         "}": begin status.cur_single = 1'b1; status.cur_kind = TK_RBRACE; end
         default: ;
      endcase

      // A cut identifier never counts as a keyword.
      if (!ovf_ff) begin
         if ((len_ff == LEN_W'(4)) && (buf_ff[0] == "t") && (buf_ff[1] == "r") &&
             (buf_ff[2] == "u") && (buf_ff[3] == "e")) begin
            status.kw_hit  = 1'b1;
            status.kw_kind = TK_TRUE;
         end else if ((len_ff == LEN_W'(5)) && (buf_ff[0] == "f") &&
                      (buf_ff[1] == "a") && (buf_ff[2] == "l") &&
                      (buf_ff[3] == "s") && (buf_ff[4] == "e")) begin
            status.kw_hit  = 1'b1;
            status.kw_kind = TK_FALSE;
         end else if ((len_ff == LEN_W'(2)) && (buf_ff[0] == "i") &&
                      (buf_ff[1] == "f")) begin
            status.kw_hit  = 1'b1;
            status.kw_kind = TK_IF;
         end else if ((len_ff == LEN_W'(4)) && (buf_ff[0] == "e") &&
                      (buf_ff[1] == "l") && (buf_ff[2] == "s") &&
                      (buf_ff[3] == "e")) begin
            status.kw_hit  = 1'b1;
            status.kw_kind = TK_ELSE;
         end
      end
   end

   // Result word built for an emit command.
   always_comb begin
      new_rec = '0;
      unique case (cmd.sel)
         ES_INT: begin
            new_rec.token_kind   = TK_INT;
            new_rec.number_value = acc_ff;
         end
         ES_CHAR: begin
            new_rec.token_kind = TK_IDENT;
            new_rec.text_char  = buf_ff[idx_ff];
            new_rec.text_index = 4'(idx_ff);
            new_rec.text_end   = status.chars_done;
            new_rec.truncated  = ovf_ff;
         end
         default: begin
            new_rec.token_kind = cmd.kind;
         end
      endcase
   end

   always_comb begin
      cur_byte_in   = cur_byte_ff;
      cur_last_in   = cur_last_ff;
      fin_in        = fin_ff;
      pend_in       = pend_ff;
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      buf_we        = 1'b0;
      buf_addr      = len_ff[IDX_W-1:0];

      if (cmd.latch) begin
         cur_byte_in = req_byte_in;
         cur_last_in = req_end_of_source;
      end
      if (cmd.fin_clr) begin
         fin_in = 1'b0;
      end
      if (cmd.fin_set) begin
         fin_in = 1'b1;
      end
      if (cmd.pend_clr) begin
         pend_in = 8'd0;
      end
      if (cmd.pend_set) begin
         pend_in = eff_c;
      end
      if (cmd.mode_we) begin
         mode_in = cmd.mode_val;
      end

      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_start) begin
         acc_in = NUMBER_WIDTH'(digit);
      end else if (cmd.acc_step) begin
         // Times ten as two shifts; the sum wraps at the accumulator width.
         acc_in = (acc_ff << 3) + (acc_ff << 1) + NUMBER_WIDTH'(digit);
      end

      if (cmd.id_clr) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.id_start) begin
         buf_we   = 1'b1;
         buf_addr = '0;
         len_in   = LEN_W'(1);
         ovf_in   = 1'b0;
      end else if (cmd.id_append) begin
         if (len_room) begin
            buf_we = 1'b1;
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // The staged word goes out once the next one, or the end of the byte,
      // tells whether it was the last of its run.
      if (push) begin
         out_in          = hold_ff;
         out_in.run_last = cmd.drain;
         out_valid_in    = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         hold_in       = new_rec;
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[buf_addr] <= eff_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff        <= 1'b0;
         pend_ff       <= 8'd0;
         mode_ff       <= MODE_IDLE;
         acc_ff        <= '0;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         fin_ff        <= fin_in;
         pend_ff       <= pend_in;
         mode_ff       <= mode_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      cur_last_ff <= cur_last_in;
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// File: rtl/core/exlex_ctrl.sv
// ----------------------------------------------------------------------------
// exlex_ctrl
// Lexer sequencer: walks each byte through pending-operator resolution,
// closing of the open token and start of a new one, then a second closing
// pass with a terminator when the source ends.
// ----------------------------------------------------------------------------
module exlex_ctrl
   import exlex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PEND  = 6'b000010,
      ST_MODE  = 6'b000100,
      ST_CHARS = 6'b001000,
      ST_NEW   = 6'b010000,
      ST_DRAIN = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           pass2_ff, pass2_in;
   logic           close_ff, close_in;
   ctrl_state_type pass_end;

   // After the byte's own pass, either run the closing pass or finish.
   assign pass_end = close_ff ? ST_PEND : ST_DRAIN;

   always_comb begin
      state_in  = state_ff;
      pass2_in  = pass2_ff;
      close_in  = close_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.pass2 = pass2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (status.finished) begin
                  // Bytes after an early zero are dropped up to the marked one.
                  cmd.fin_clr = status.in_last;
               end else begin
                  pass2_in = status.in_zero;
                  close_in = status.in_zero || status.in_last;
                  state_in = ST_PEND;
               end
            end
         end

         ST_PEND: begin
            if (!status.pend_busy) begin
               state_in = ST_MODE;
            end else if (status.pend_pair) begin
               if (status.slot_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.kind     = status.pair_kind;
                  cmd.pend_clr = 1'b1;
                  pass2_in     = close_ff;
                  state_in     = pass_end;
               end
            end else if (status.pend_single) begin
               if (status.slot_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.kind     = status.pend_kind;
                  cmd.pend_clr = 1'b1;
                  state_in     = ST_MODE;
               end
            end else begin
               cmd.pend_clr = 1'b1;
               state_in     = ST_MODE;
            end
         end

         ST_MODE: begin
            unique case (status.mode)
               MODE_NUM: begin
                  if (status.cur_digit) begin
                     cmd.acc_step = 1'b1;
                     pass2_in     = close_ff;
                     state_in     = pass_end;
                  end else if (status.slot_ok) begin
                     cmd.emit     = 1'b1;
                     cmd.sel      = ES_INT;
                     cmd.acc_clr  = 1'b1;
                     cmd.mode_we  = 1'b1;
                     cmd.mode_val = MODE_IDLE;
                     state_in     = ST_NEW;
                  end
               end
               MODE_IDENT: begin
                  if (status.cur_alnum) begin
                     cmd.id_append = 1'b1;
                     pass2_in      = close_ff;
                     state_in      = pass_end;
                  end else if (status.kw_hit) begin
                     if (status.slot_ok) begin
                        cmd.emit     = 1'b1;
                        cmd.kind     = status.kw_kind;
                        cmd.id_clr   = 1'b1;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = MODE_IDLE;
                        state_in     = ST_NEW;
                     end
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_CHARS;
                  end
               end
               default: begin
                  state_in = ST_NEW;
               end
            endcase
         end

         ST_CHARS: begin
            if (status.slot_ok) begin
               cmd.emit = 1'b1;
               cmd.sel  = ES_CHAR;
               if (status.chars_done) begin
                  cmd.id_clr   = 1'b1;
                  cmd.mode_we  = 1'b1;
                  cmd.mode_val = MODE_IDLE;
                  state_in     = ST_NEW;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end

         ST_NEW: begin
            if (pass2_ff) begin
               if (status.slot_ok) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = TK_END;
                  cmd.fin_set = !status.cur_last;
                  state_in    = ST_DRAIN;
               end
            end else if (status.cur_single) begin
               if (status.slot_ok) begin
                  cmd.emit = 1'b1;
                  cmd.kind = status.cur_kind;
                  pass2_in = close_ff;
                  state_in = pass_end;
               end
            end else begin
               pass2_in = close_ff;
               state_in = pass_end;
               priority if (status.cur_space) begin
                  cmd.acc_clr = 1'b0;
               end else if (status.cur_digit) begin
                  cmd.acc_start = 1'b1;
                  cmd.mode_we   = 1'b1;
                  cmd.mode_val  = MODE_NUM;
               end else if (status.cur_alpha) begin
                  cmd.id_start = 1'b1;
                  cmd.mode_we  = 1'b1;
                  cmd.mode_val = MODE_IDENT;
               end else if (status.cur_pend_op) begin
                  cmd.pend_set = 1'b1;
               end else begin
                  cmd.pend_set = 1'b0;
               end
            end
         end

         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (!status.hold_valid || status.out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass2_ff <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
         close_ff <= close_in;
      end
   end

endmodule

// File: rtl/core/expression_lexer.sv
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming tokenizer for a small expression language, one source byte per
// word in, one token or identifier character per word out.
// ----------------------------------------------------------------------------
// Each source byte is accepted only while the sequencer is idle. A byte that
// completes a two-character operator passes through the pending and drain
// states; one that extends a number or identifier through the pending, mode
// and drain states; any other byte through the pending, mode, new-token and
// drain states. An identifier that is not a keyword goes out one character
// per cycle while the result port is free, so that run sets the worst case
// (up to eighteen results for one byte). A byte that closes the source runs
// a second closing pass through the pending, mode and new-token states, plus
// the characters of any identifier it flushes. Results of a byte are staged
// one word behind so that run_last can be set on the final one; a stalled
// result port holds the sequencer. Bytes after an early zero byte are dropped
// at one per cycle up to and including the next byte marked end_of_source.
module expression_lexer
   import exlex_pkg::*;
(
   input logic        clock,
   input logic        reset,
   exlex_req_if.sink  req_chan,
   exlex_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_word;
   logic       rsp_valid;

   exlex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   exlex_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_byte_in       (req_chan.byte_in),
      .req_end_of_source (req_chan.end_of_source),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_valid),
      .rsp_word          (rsp_word)
   );

   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.token_kind   = rsp_word.token_kind;
   assign rsp_chan.number_value = rsp_word.number_value;
   assign rsp_chan.text_char    = rsp_word.text_char;
   assign rsp_chan.text_index   = rsp_word.text_index;
   assign rsp_chan.text_end     = rsp_word.text_end;
   assign rsp_chan.truncated    = rsp_word.truncated;
   assign rsp_chan.run_last     = rsp_word.run_last;

   // END closes the run of results of its byte.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.token_kind == TK_END)) |-> rsp_chan.run_last)
      else $error("END word without run_last");

   // Only identifier characters carry an end-of-text mark.
   a_text_end_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.text_end) |-> (rsp_chan.token_kind == TK_IDENT))
      else $error("text_end on a non-identifier word");

   // A new byte is taken only after the previous run has left the staging word.
   a_ready_no_stage: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !status.hold_valid)
      else $error("ready while a result is still staged");

endmodule

// File: test/expression_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_lexer_tb
// Self-checking bench for the expression lexer. Source bytes go in through a
// driver with random gaps and come out as token words through a monitor with
// random stalls; a cycle-accurate-free token predictor inside the bench
// builds the expected words for every accepted byte and the monitor checks
// each word, in order, against them.
// ----------------------------------------------------------------------------
module expression_lexer_tb;
   import exlex_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BYTES = 100;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [7:0] code;
      bit         last;
      int         gap;
      bit         hold;
   } source_byte_type;

   logic clock;
   logic reset;

   exlex_req_if req_if();
   exlex_rsp_if rsp_if();

   expression_lexer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Token predictor state.
   scan_mode_type lex_mode;
   logic [7:0]    lex_pending;
   logic [31:0]   lex_accum;
   logic [7:0]    lex_ident [IDENT_MAX];
   int            lex_ident_len;
   bit            lex_overflow;
   bit            lex_finished;

   rsp_type          expected_tokens[$];
   source_byte_type  source_bytes[$];
   source_byte_type  next_byte;

   bit            tx_steady;
   bit            hold_next;
   bit            rx_steady;
   int            idle_left;
   int            stall_left;
   int            error_count;
   int            bytes_sent;
   int            tokens_checked;
   int            sources_made;
   int            cycle_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------
   function automatic void lexer_clear();
      int i;
      lex_mode      = MODE_IDLE;
      lex_pending   = 8'd0;
      lex_accum     = 32'd0;
      lex_ident_len = 0;
      lex_overflow  = 1'b0;
      lex_finished  = 1'b0;
      for (i = 0; i < IDENT_MAX; i++) lex_ident[i] = 8'd0;
   endfunction

   function automatic void push_token(token_kind_type kind, logic [31:0] num,
                                      logic [7:0] ch, logic [3:0] idx,
                                      bit fin, bit cut);
      rsp_type t;
      t.token_kind   = kind;
      t.number_value = num;
      t.text_char    = ch;
      t.text_index   = idx;
      t.text_end     = fin;
      t.truncated    = cut;
      t.run_last     = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic void push_op(token_kind_type kind);
      push_token(kind, 32'd0, 8'd0, 4'd0, 1'b0, 1'b0);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void flush_ident();
      logic [39:0] head;
      int i;
      head = {lex_ident[0], lex_ident[1], lex_ident[2], lex_ident[3], lex_ident[4]};
      if (!lex_overflow && lex_ident_len == 4 && head[39:8] == "true")
         push_op(TK_TRUE);
      else if (!lex_overflow && lex_ident_len == 5 && head == "false")
         push_op(TK_FALSE);
      else if (!lex_overflow && lex_ident_len == 2 && head[39:24] == "if")
         push_op(TK_IF);
      else if (!lex_overflow && lex_ident_len == 4 && head[39:8] == "else")
         push_op(TK_ELSE);
      else begin
         for (i = 0; i < lex_ident_len; i++)
            push_token(TK_IDENT, 32'd0, lex_ident[i], i[3:0],
                       i + 1 == lex_ident_len, lex_overflow);
      end
      lex_ident_len = 0;
      lex_overflow  = 1'b0;
   endfunction

   // A held operator byte that found no partner stands as a token of its own,
   // except a lone & or |, which is simply dropped.
   function automatic void resolve_single();
      case (lex_pending)
         "=": push_op(TK_ASSIGN);
         "!": push_op(TK_BANG);
         "<": push_op(TK_LT);
         ">": push_op(TK_GT);
         default: ;
      endcase
      lex_pending = 8'd0;
   endfunction

   function automatic void append_ident(logic [7:0] c);
      if (lex_ident_len < IDENT_MAX) begin
         lex_ident[lex_ident_len] = c;
         lex_ident_len++;
      end else begin
         lex_overflow = 1'b1;
      end
   endfunction

   function automatic void flush_all();
      if (lex_pending != 8'd0) resolve_single();
      if (lex_mode == MODE_NUM)
         push_token(TK_INT, lex_accum, 8'd0, 4'd0, 1'b0, 1'b0);
      else if (lex_mode == MODE_IDENT)
         flush_ident();
      lex_mode      = MODE_IDLE;
      lex_accum     = 32'd0;
      lex_ident_len = 0;
      lex_overflow  = 1'b0;
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      if (lex_pending != 8'd0) begin
         if (c == "=" && (lex_pending == "=" || lex_pending == "!" ||
                          lex_pending == "<" || lex_pending == ">")) begin
            case (lex_pending)
               "=": push_op(TK_EQ);
               "!": push_op(TK_NE);
               "<": push_op(TK_LE);
               default: push_op(TK_GE);
            endcase
            lex_pending = 8'd0;
            return;
         end
         if ((c == "&" || c == "|") && c == lex_pending) begin
            push_op(c == "&" ? TK_AND : TK_OR);
            lex_pending = 8'd0;
            return;
         end
         resolve_single();
      end
      if (lex_mode == MODE_NUM) begin
         if (is_digit(c)) begin
            lex_accum = lex_accum * 32'd10 + {28'd0, c[3:0]};
            return;
         end
         push_token(TK_INT, lex_accum, 8'd0, 4'd0, 1'b0, 1'b0);
         lex_accum = 32'd0;
         lex_mode  = MODE_IDLE;
      end else if (lex_mode == MODE_IDENT) begin
         if (is_alpha(c) || is_digit(c)) begin
            append_ident(c);
            return;
         end
         flush_ident();
         lex_mode = MODE_IDLE;
      end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      if (is_digit(c)) begin
         lex_accum = {28'd0, c[3:0]};
         lex_mode  = MODE_NUM;
         return;
      end
      if (is_alpha(c)) begin
         lex_ident_len = 0;
         lex_overflow  = 1'b0;
         append_ident(c);
         lex_mode = MODE_IDENT;
         return;
      end
      case (c)
         "=", "!", "<", ">", "&", "|": lex_pending = c;
         "+": push_op(TK_PLUS);
         "-": push_op(TK_MINUS);
         "*": push_op(TK_STAR);
         "/": push_op(TK_SLASH);
         "%": push_op(TK_PCT);
         "(": push_op(TK_LPAREN);
         ")": push_op(TK_RPAREN);
         "^": push_op(TK_CARET);
         "{": push_op(TK_LBRACE);
         "}": push_op(TK_RBRACE);
         default: ;
      endcase
   endfunction

   // Expected words for one accepted source byte; the final one carries run_last.
   function automatic void predict_tokens(logic [7:0] c, bit last);
      int before_count;
      rsp_type t;
      before_count = expected_tokens.size();
      if (lex_finished) begin
         if (last) lex_finished = 1'b0;
         return;
      end
      if (c != 8'd0) scan_byte(c);
      if (c == 8'd0 || last) begin
         flush_all();
         push_op(TK_END);
         if (!last) lex_finished = 1'b1;
      end
      if (expected_tokens.size() > before_count) begin
         t = expected_tokens.pop_back();
         t.run_last = 1'b1;
         expected_tokens.insert(expected_tokens.size(), t);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] code, input bit last);
      source_byte_type b;
      b.code    = code;
      b.last    = last;
      b.gap     = tx_steady ? 0 : $urandom_range(0, 10);
      b.hold    = hold_next;
      hold_next = 1'b0;
      source_bytes.insert(source_bytes.size(), b);
   endtask

   task automatic add_text(input string s, input bit last);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i], last && i == s.len() - 1);
   endtask

   task automatic mark_last();
      source_byte_type b;
      b = source_bytes.pop_back();
      b.last = 1'b1;
      source_bytes.insert(source_bytes.size(), b);
   endtask

   function automatic logic [7:0] random_alpha();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   // One source text of random tokens; the first one forces a twelve-digit number
   // and an identifier longer than the buffer.
   task automatic add_random_source(input bit extremes);
      int ntok, pick, len, i, t;
      string s;
      tx_steady = ($urandom_range(0, 3) == 0);
      hold_next = extremes || ($urandom_range(0, 4) == 0);
      ntok = extremes ? 3 : $urandom_range(1, 8);
      for (t = 0; t < ntok; t++) begin
         pick = extremes ? t : $urandom_range(0, 9);
         case (pick)
            0, 5: begin
               len = extremes ? 12 :
                     ($urandom_range(0, 7) == 0 ? $urandom_range(10, 12) :
                                                  $urandom_range(1, 4));
               for (i = 0; i < len; i++) add_byte(8'("0" + $urandom_range(0, 9)), 0);
            end
            1, 6: begin
               len = extremes ? 20 :
                     ($urandom_range(0, 7) == 0 ? $urandom_range(15, 19) :
                                                  $urandom_range(1, 5));
               add_byte(random_alpha(), 0);
               for (i = 1; i < len; i++)
                  add_byte($urandom_range(0, 4) == 0 ? 8'("0" + $urandom_range(0, 9)) :
                                                       random_alpha(), 0);
            end
            2: begin
               case ($urandom_range(0, 5))
                  0: s = "true";
                  1: s = "false";
                  2: s = "if";
                  3: s = "else";
                  4: s = "tru";
                  default: s = "iff";
               endcase
               add_text(s, 0);
            end
            3, 4: begin
               case ($urandom_range(0, 21))
                  0: s = "==";  1: s = "!=";  2: s = "<=";  3: s = ">=";
                  4: s = "&&";  5: s = "||";  6: s = "+";   7: s = "-";
                  8: s = "*";   9: s = "/";  10: s = "%";  11: s = "(";
                  12: s = ")"; 13: s = "^";  14: s = "!";  15: s = "=";
                  16: s = "<"; 17: s = ">";  18: s = "{";  19: s = "}";
                  20: s = "&";
                  default: s = "|";
               endcase
               add_text(s, 0);
            end
            7: begin
               len = $urandom_range(8, 13);
               add_byte(len == 8 ? 8'h20 : 8'(len), 0);
            end
            default: add_byte(8'($urandom_range(1, 255)), 0);
         endcase
         if ($urandom_range(0, 1) == 0) add_byte(" ", 0);
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         // Early zero: the tail up to the marked byte must produce nothing.
         add_byte(8'h00, 0);
         len = $urandom_range(0, 3);
         for (i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)), 0);
         add_byte(8'($urandom_range(0, 255)), 1);
      end else if (pick == 1) begin
         add_byte(8'h00, 1);
      end else if (pick < 5) begin
         mark_last();
      end else begin
         add_byte(8'($urandom_range(0, 255)), 1);
      end
      sources_made++;
   endtask

   // ------------------------------------------------------------------
   // Source byte driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_tokens(req_if.byte_in, req_if.end_of_source);
            bytes_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_if.valid <= 1'b0;
            end else if (source_bytes.size() > 0) begin
               next_byte = source_bytes[0];
               if (next_byte.hold && expected_tokens.size() > 0) begin
                  req_if.valid <= 1'b0;
               end else begin
                  next_byte = source_bytes.pop_front();
                  req_if.valid         <= 1'b1;
                  req_if.byte_in       <= next_byte.code;
                  req_if.end_of_source <= next_byte.last;
                  idle_left = next_byte.gap;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Token monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.token_kind   = rsp_if.token_kind;
            got.number_value = rsp_if.number_value;
            got.text_char    = rsp_if.text_char;
            got.text_index   = rsp_if.text_index;
            got.text_end     = rsp_if.text_end;
            got.truncated    = rsp_if.truncated;
            got.run_last     = rsp_if.run_last;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
               error_count++;
               $display("%0t unexpected word: expected none, actual %0d/%0d/%h/%0d/%b/%b/%b",
                        $time, got.token_kind, got.number_value, got.text_char,
                        got.text_index, got.text_end, got.truncated, got.run_last);
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t mismatch (kind/value/char/index/end/truncated/last):",
                           $time, " expected %0d/%0d/%h/%0d/%b/%b/%b",
                           want.token_kind, want.number_value, want.text_char,
                           want.text_index, want.text_end, want.truncated,
                           want.run_last, " actual %0d/%0d/%h/%0d/%b/%b/%b",
                           got.token_kind, got.number_value, got.text_char,
                           got.text_index, got.text_end, got.truncated, got.run_last);
               end
            end
            stall_left = rx_steady ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int directed_count;
      bit first;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.byte_in       = 8'd0;
      req_if.end_of_source = 1'b0;
      rsp_if.ready         = 1'b0;
      error_count          = 0;
      bytes_sent           = 0;
      tokens_checked       = 0;
      sources_made         = 0;
      cycle_count          = 0;
      rx_steady            = 1'b0;
      lexer_clear();

      // Directed sources: keyword, paren, pair operator and number; lone & and
      // | with a high unknown byte closing the text; early zero with an ignored
      // tail; a bare keyword.
      tx_steady = 1'b1;
      hold_next = 1'b0;
      add_text("if(x_9>=42)", 1);
      add_text("a&|b!", 0);
      add_byte(8'hFF, 1);
      add_text("7", 0);
      add_byte(8'h00, 0);
      add_text("zzq", 1);
      add_text("else", 1);
      sources_made = 4;
      directed_count = source_bytes.size();

      first = 1'b1;
      while (source_bytes.size() < directed_count + RANDOM_BYTES) begin
         add_random_source(first);
         first = 1'b0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (source_bytes.size() > 0 || req_if.valid || expected_tokens.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_tokens.size() > 0) begin
         error_count++;
         $display("%0t %0d expected words never arrived", $time, expected_tokens.size());
      end
      $display("Sent %0d source bytes in %0d source texts, checked %0d token words.",
               bytes_sent, sources_made, tokens_checked);
      $display("Mismatched or stray words: %0d.", error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
